// ----- hw/rtl/four_level_symbol_slicer_unit_macros.svh -----
// Assertion macros shared by the slicer RTL.
`ifndef FOUR_LEVEL_SYMBOL_SLICER_UNIT_MACROS_SVH
`define FOUR_LEVEL_SYMBOL_SLICER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FLSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slicer check failed");
`define FLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slicer check failed");
`else
`define FLSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/flss_pkg.sv -----
`default_nettype none
package flss_pkg;

  localparam int AVG_DEPTH_DEF = 16;
  localparam int SAMPLE_W      = 16;

  localparam logic signed [SAMPLE_W-1:0] TRACK_HIGH = 16'sd16000;
  localparam logic signed [SAMPLE_W-1:0] TRACK_LOW  = -16'sd16000;

  localparam logic KIND_DIBIT = 1'b0;
  localparam logic KIND_LEVEL = 1'b1;

  typedef enum logic [1:0] {
    OP_ACC    = 2'd0,
    OP_FINISH = 2'd1,
    OP_SLICE  = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIBIT_MIDLOW  = 2'b00,
    DIBIT_LOW     = 2'b01,
    DIBIT_MIDHIGH = 2'b10,
    DIBIT_HIGH    = 2'b11
  } dibit_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_NEG,
    ST_CEN,
    ST_THR,
    ST_WR,
    ST_RD,
    ST_ACC_C,
    ST_ACC_T,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/flss_ram.sv -----
`default_nettype none
module flss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/flss_addsub.sv -----
`default_nettype none
module flss_addsub #(
  parameter int WIDTH = 21
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  input  wire logic             sub,
  output logic      [WIDTH-1:0] y
);

  // Subtraction is a plus the ones' complement of b plus one.
  assign y = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule
`default_nettype wire

// ----- hw/rtl/four_level_symbol_slicer_unit.sv -----
// Four-level symbol slicer with adaptive levels. Accumulate (operation 0) and
// set-start (operation 3) items give no result; a slice item (operation 2)
// puts its dibit in the output register, where it sits the next cycle. A
// finish-block item (operation 1) runs on one shared adder under a sequencer:
// the positive and negative mid-levels, centre and threshold, one ring write
// (AVERAGE_DEPTH writes on the first block after reset or a set-start item), a
// read and a centre and a threshold sum per ring entry, then for each of the
// two averages its magnitude, a multiply by a fixed reciprocal of
// AVERAGE_DEPTH and its sign, and last the output step, which waits while an
// earlier result is still held. The block takes no new item while a
// finish-block item is in progress or while a result waits for the receiver.
`default_nettype none
`include "four_level_symbol_slicer_unit_macros.svh"
module four_level_symbol_slicer_unit #(
  parameter int AVERAGE_DEPTH = flss_pkg::AVG_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           in_operation,
  input  wire logic signed [flss_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                                 in_invert,
  input  wire logic signed [flss_pkg::SAMPLE_W-1:0] in_start_centre,
  input  wire logic signed [flss_pkg::SAMPLE_W-1:0] in_start_threshold,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_kind,
  output logic [1:0]                                out_dibit,
  output logic signed [flss_pkg::SAMPLE_W-1:0]      out_centre_level,
  output logic signed [flss_pkg::SAMPLE_W-1:0]      out_threshold_level
);

  import flss_pkg::*;

  localparam int SW = SAMPLE_W + $clog2(AVERAGE_DEPTH);
  localparam int AW = SW + 1;
  localparam int IW = $clog2(AVERAGE_DEPTH);
  localparam int RW = 2 * SAMPLE_W;

  // The reciprocal is exact for every magnitude below 2**SW.
  localparam int RECIP_SHIFT = SW + IW;
  localparam logic [SW:0] RECIP =
    (SW+1)'((64'd1 << RECIP_SHIFT) / 64'(AVERAGE_DEPTH) + 64'd1);

  function automatic logic [AW-1:0] sx(input logic [SAMPLE_W-1:0] v);
    sx = {{(AW-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] pos_max_r, pos_max_nxt, pos_min_r, pos_min_nxt;
  logic signed [SAMPLE_W-1:0] neg_max_r, neg_max_nxt, neg_min_r, neg_min_nxt;
  logic signed [SAMPLE_W-1:0] cur_c_r, cur_c_nxt, cur_t_r, cur_t_nxt;
  logic [IW-1:0]              ring_pos_r, ring_pos_nxt;
  logic                       unfilled_r, unfilled_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0] pos_r, pos_nxt, neg_r, neg_nxt, cen_r, cen_nxt;
  logic [SAMPLE_W-1:0] thr_r, thr_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [SW-1:0]       csum_r, csum_nxt, tsum_r, tsum_nxt, div_r, div_nxt;
  logic                sel_r, sel_nxt, sign_r, sign_nxt;

  logic                       out_kind_r, out_kind_nxt;
  logic [1:0]                 out_dibit_r, out_dibit_nxt;
  logic [SAMPLE_W-1:0]        out_c_r, out_c_nxt, out_t_r, out_t_nxt;

  logic [AW-1:0] alu_a, alu_b, alu_y, half_tmp, half_y;
  logic          alu_sub;
  logic [2*SW:0] div_prod;

  logic          ram_we;
  logic [IW-1:0] ram_wr_addr, ram_rd_addr;
  logic [RW-1:0] ram_rd_data;

  logic          in_fire;
  logic [SW-1:0] sum_sel;

  logic signed [SAMPLE_W+1:0] sl_x, sl_d, sl_thr, sl_nthr;
  dibit_t                     sl_dibit;

  flss_addsub #(.WIDTH(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  flss_ram #(.WIDTH(RW), .DEPTH(AVERAGE_DEPTH)) u_ring (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data ({cen_r, thr_r}),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready  = rst_n && (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_dibit           = out_dibit_r;
  assign out_centre_level    = out_c_r;
  assign out_threshold_level = out_t_r;

  // Halving of the adder output, truncating toward zero.
  assign half_tmp  = alu_y + AW'(alu_y[AW-1]);
  assign half_y    = {half_tmp[AW-1], half_tmp[AW-1:1]};
  assign sum_sel   = sel_r ? tsum_r : csum_r;
  assign div_prod  = (2*SW+1)'(div_r) * (2*SW+1)'(RECIP);

  // Slicing is done at full width so that negating -32768 stays exact.
  always_comb begin
    sl_x    = in_invert ? -18'(in_sample) : 18'(in_sample);
    sl_d    = sl_x - 18'(cur_c_r);
    sl_thr  = 18'(cur_t_r);
    sl_nthr = -sl_thr;
    if (sl_d < sl_nthr) begin
      sl_dibit = DIBIT_LOW;
    end else if (sl_d < 18'sd0) begin
      sl_dibit = DIBIT_MIDLOW;
    end else if (sl_d < sl_thr) begin
      sl_dibit = DIBIT_MIDHIGH;
    end else begin
      sl_dibit = DIBIT_HIGH;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pos_max_nxt   = pos_max_r;
    pos_min_nxt   = pos_min_r;
    neg_max_nxt   = neg_max_r;
    neg_min_nxt   = neg_min_r;
    cur_c_nxt     = cur_c_r;
    cur_t_nxt     = cur_t_r;
    ring_pos_nxt  = ring_pos_r;
    unfilled_nxt  = unfilled_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    cen_nxt       = cen_r;
    thr_nxt       = thr_r;
    idx_nxt       = idx_r;
    csum_nxt      = csum_r;
    tsum_nxt      = tsum_r;
    div_nxt       = div_r;
    sel_nxt       = sel_r;
    sign_nxt      = sign_r;
    out_kind_nxt  = out_kind_r;
    out_dibit_nxt = out_dibit_r;
    out_c_nxt     = out_c_r;
    out_t_nxt     = out_t_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    ram_we        = 1'b0;
    ram_wr_addr   = unfilled_r ? idx_r : ring_pos_r;
    ram_rd_addr   = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(in_operation))
            OP_ACC: begin
              if (in_sample > 16'sd0) begin
                if (in_sample > pos_max_r) pos_max_nxt = in_sample;
                if (in_sample < pos_min_r) pos_min_nxt = in_sample;
              end else begin
                if (in_sample < neg_max_r) neg_max_nxt = in_sample;
                if (in_sample > neg_min_r) neg_min_nxt = in_sample;
              end
            end
            OP_FINISH: begin
              state_nxt = ST_POS;
            end
            OP_SLICE: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_DIBIT;
              out_dibit_nxt = sl_dibit;
              out_c_nxt     = '0;
              out_t_nxt     = '0;
            end
            OP_START: begin
              cur_c_nxt    = in_start_centre;
              cur_t_nxt    = in_start_threshold;
              unfilled_nxt = 1'b1;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_POS: begin
        alu_a     = sx(pos_max_r);
        alu_b     = sx(pos_min_r);
        pos_nxt   = half_y[SAMPLE_W-1:0];
        state_nxt = ST_NEG;
      end
      ST_NEG: begin
        alu_a     = sx(neg_max_r);
        alu_b     = sx(neg_min_r);
        neg_nxt   = half_y[SAMPLE_W-1:0];
        state_nxt = ST_CEN;
      end
      ST_CEN: begin
        alu_a       = sx(pos_r);
        alu_b       = sx(neg_r);
        cen_nxt     = half_y[SAMPLE_W-1:0];
        pos_max_nxt = TRACK_LOW;
        pos_min_nxt = TRACK_HIGH;
        neg_max_nxt = TRACK_HIGH;
        neg_min_nxt = TRACK_LOW;
        state_nxt   = ST_THR;
      end
      ST_THR: begin
        alu_a     = sx(pos_r);
        alu_b     = sx(cen_r);
        alu_sub   = 1'b1;
        thr_nxt   = alu_y[SAMPLE_W-1:0];
        idx_nxt   = '0;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // A refill writes every entry in turn; otherwise one entry at the ring position.
        ram_we = 1'b1;
        if (unfilled_r && (idx_r != IW'(AVERAGE_DEPTH - 1))) begin
          idx_nxt = idx_r + IW'(1);
        end else begin
          if (unfilled_r) begin
            ring_pos_nxt = '0;
            unfilled_nxt = 1'b0;
          end else if (ring_pos_r == IW'(AVERAGE_DEPTH - 1)) begin
            ring_pos_nxt = '0;
          end else begin
            ring_pos_nxt = ring_pos_r + IW'(1);
          end
          idx_nxt   = '0;
          csum_nxt  = '0;
          tsum_nxt  = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_ACC_C;
      end
      ST_ACC_C: begin
        alu_a     = {csum_r[SW-1], csum_r};
        alu_b     = sx(ram_rd_data[RW-1:SAMPLE_W]);
        csum_nxt  = alu_y[SW-1:0];
        state_nxt = ST_ACC_T;
      end
      ST_ACC_T: begin
        alu_a    = {tsum_r[SW-1], tsum_r};
        alu_b    = sx(ram_rd_data[SAMPLE_W-1:0]);
        tsum_nxt = alu_y[SW-1:0];
        if (idx_r == IW'(AVERAGE_DEPTH - 1)) begin
          sel_nxt   = 1'b0;
          state_nxt = ST_ABS;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_ABS: begin
        alu_a     = '0;
        alu_b     = {sum_sel[SW-1], sum_sel};
        alu_sub   = 1'b1;
        sign_nxt  = sum_sel[SW-1];
        div_nxt   = sum_sel[SW-1] ? alu_y[SW-1:0] : sum_sel;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // The high bits of the product with the reciprocal are the quotient.
        div_nxt   = SW'(div_prod >> RECIP_SHIFT);
        state_nxt = ST_SIGN;
      end
      ST_SIGN: begin
        alu_a   = '0;
        alu_b   = {1'b0, div_r};
        alu_sub = sign_r;
        if (!sel_r) begin
          cur_c_nxt = alu_y[SAMPLE_W-1:0];
          sel_nxt   = 1'b1;
          state_nxt = ST_ABS;
        end else begin
          cur_t_nxt = alu_y[SAMPLE_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_LEVEL;
          out_dibit_nxt = '0;
          out_c_nxt     = cur_c_r;
          out_t_nxt     = cur_t_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_max_r   <= TRACK_LOW;
      pos_min_r   <= TRACK_HIGH;
      neg_max_r   <= TRACK_HIGH;
      neg_min_r   <= TRACK_LOW;
      cur_c_r     <= '0;
      cur_t_r     <= '0;
      ring_pos_r  <= '0;
      unfilled_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_max_r   <= pos_max_nxt;
      pos_min_r   <= pos_min_nxt;
      neg_max_r   <= neg_max_nxt;
      neg_min_r   <= neg_min_nxt;
      cur_c_r     <= cur_c_nxt;
      cur_t_r     <= cur_t_nxt;
      ring_pos_r  <= ring_pos_nxt;
      unfilled_r  <= unfilled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    neg_r       <= neg_nxt;
    cen_r       <= cen_nxt;
    thr_r       <= thr_nxt;
    idx_r       <= idx_nxt;
    csum_r      <= csum_nxt;
    tsum_r      <= tsum_nxt;
    div_r       <= div_nxt;
    sel_r       <= sel_nxt;
    sign_r      <= sign_nxt;
    out_kind_r  <= out_kind_nxt;
    out_dibit_r <= out_dibit_nxt;
    out_c_r     <= out_c_nxt;
    out_t_r     <= out_t_nxt;
  end

  `FLSS_ASSERT_NEXT(a_start_arms_refill, clk, rst_n,
                    in_fire && (in_operation == OP_START), unfilled_r)
  `FLSS_ASSERT_NEXT(a_pos_max_tracks, clk, rst_n,
                    in_fire && (in_operation == OP_ACC) && (in_sample > 16'sd0),
                    pos_max_r >= $past(in_sample))
  `FLSS_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid_r),
                   ($past(state_r) == ST_OUT) || ($past(state_r) == ST_IDLE))
  `FLSS_ASSERT_NEXT(a_div_single_step, clk, rst_n, state_r == ST_DIV, state_r == ST_SIGN)
  `FLSS_ASSERT_NEXT(a_level_delivered, clk, rst_n,
                    (state_r == ST_OUT) && (!out_valid_r || out_ready),
                    out_valid_r && (out_kind_r == KIND_LEVEL))

endmodule
`default_nettype wire
